### rtl/ndrm_pkg.sv
`timescale 1ns / 1ps

package ndrm_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Record geometry
   localparam int NAME_BYTES  = 32;
   localparam int NAME_W      = 8 * NAME_BYTES;
   localparam int SIZE_W      = 63;
   localparam int PLEN_W      = 6;
   localparam int TOTAL_W     = 32;

   localparam logic [7:0]         HIDDEN_MARK = 8'h2E;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX   = '1;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_TOLERANCE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELETE_ENABLE  = 2'd2;

   typedef enum logic [1:0] {
      OUT_NEW    = 2'd0,
      OUT_DUP    = 2'd1,
      OUT_HIDDEN = 2'd2,
      OUT_FULL   = 2'd3
   } outcome_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // One table entry
   typedef struct packed {
      logic [NAME_W-1:0] name;
      logic [SIZE_W-1:0] size;
   } entry_type;

   // Table access request
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } tbl_req_type;

endpackage

### rtl/ndrm_table.sv
`timescale 1ns / 1ps

module ndrm_table (
   input  logic                 clock,
   input  ndrm_pkg::tbl_req_type req,
   input  ndrm_pkg::entry_type  wr_data,
   output ndrm_pkg::entry_type  rd_data
);

   ndrm_pkg::entry_type mem [ndrm_pkg::TABLE_DEPTH];
   ndrm_pkg::entry_type rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= wr_data;
      end
   end

   // single registered read port
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ndrm_cmp.sv
`timescale 1ns / 1ps

module ndrm_cmp (
   input  logic [ndrm_pkg::NAME_W-1:0] rec_name,
   input  logic [ndrm_pkg::SIZE_W-1:0] rec_size,
   input  ndrm_pkg::entry_type         entry,
   input  logic [ndrm_pkg::PLEN_W-1:0] prefix_length,
   input  logic [ndrm_pkg::SIZE_W-1:0] size_tolerance,
   output logic                        match
);

   localparam logic [ndrm_pkg::PLEN_W-1:0] FULL_LEN = ndrm_pkg::PLEN_W'(ndrm_pkg::NAME_BYTES);

   logic [ndrm_pkg::PLEN_W-1:0] cmp_len;
   logic                        name_ok;
   logic [ndrm_pkg::SIZE_W-1:0] size_diff;
   logic                        size_ok;

   // zero or an oversized prefix compares the whole name
   assign cmp_len = (prefix_length == '0 || prefix_length > FULL_LEN) ? FULL_LEN : prefix_length;

   // first byte that differs or ends both strings decides the compare
   always_comb begin
      logic       stopped;
      logic [7:0] a_byte;
      logic [7:0] b_byte;
      stopped = 1'b0;
      name_ok = 1'b1;
      for (int i = 0; i < ndrm_pkg::NAME_BYTES; i++) begin
         a_byte = rec_name[8*i +: 8];
         b_byte = entry.name[8*i +: 8];
         if (!stopped && (ndrm_pkg::PLEN_W'(i) < cmp_len)) begin
            if (a_byte != b_byte) begin
               stopped = 1'b1;
               name_ok = 1'b0;
            end else if (a_byte == 8'h00) begin
               stopped = 1'b1;
            end
         end
      end
   end

   // absolute size difference against tolerance
   assign size_diff = (rec_size >= entry.size) ? (rec_size - entry.size)
                                               : (entry.size - rec_size);
   assign size_ok   = (size_diff <= size_tolerance);

   assign match = name_ok & size_ok;

endmodule

### rtl/near_duplicate_record_matcher.sv
`timescale 1ns / 1ps
// A hidden record gives its result in the cycle after start is taken; any other record
// scans the stored entries in order and ends on the first hit, or on a miss once all are compared.
// Throughput: one record at a time; the scan reads one table entry per cycle
// through the single memory read port and the shared compare unit.
// Reset clears counters, config to defaults (prefix 20), and the sequencer; the
// table itself is not cleared. Results are one-cycle strobes and cannot be stalled.
module near_duplicate_record_matcher (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [63:0]                   req_name_bytes_0_7,
   input  logic [63:0]                   req_name_bytes_8_15,
   input  logic [63:0]                   req_name_bytes_16_23,
   input  logic [63:0]                   req_name_bytes_24_31,
   input  logic [ndrm_pkg::SIZE_W-1:0]   req_file_size,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_outcome,
   output logic [ndrm_pkg::ADDR_W-1:0]   rsp_match_index,
   output logic [ndrm_pkg::SIZE_W-1:0]   rsp_matched_size,
   output logic                          rsp_delete_request,
   output logic [ndrm_pkg::TOTAL_W-1:0]  rsp_duplicate_total,
   output logic [ndrm_pkg::TOTAL_W-1:0]  rsp_scanned_total,
   output logic [ndrm_pkg::CNT_W-1:0]    rsp_entries_stored,
   input  logic                          csr_write,
   input  logic [ndrm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ndrm_pkg::SIZE_W-1:0]   csr_wdata
);

   localparam logic [ndrm_pkg::CNT_W-1:0] DEPTH_CNT = ndrm_pkg::CNT_W'(ndrm_pkg::TABLE_DEPTH);

   // config
   logic [ndrm_pkg::PLEN_W-1:0] prefix_length_ff;
   logic [ndrm_pkg::SIZE_W-1:0] size_tolerance_ff;
   logic                        delete_enable_ff;

   // sequencer
   ndrm_pkg::state_type state_ff, state_in;
   logic [ndrm_pkg::CNT_W-1:0]  issue_idx_ff, issue_idx_in;
   logic                        chk_valid_ff, chk_valid_in;
   logic [ndrm_pkg::ADDR_W-1:0] chk_idx_ff, chk_idx_in;

   // record under search
   logic [ndrm_pkg::NAME_W-1:0] rec_name_ff, rec_name_in;
   logic [ndrm_pkg::SIZE_W-1:0] rec_size_ff, rec_size_in;

   // counters
   logic [ndrm_pkg::CNT_W-1:0]   entry_count_ff, entry_count_in;
   logic [ndrm_pkg::TOTAL_W-1:0] dup_total_ff, dup_total_in;
   logic [ndrm_pkg::TOTAL_W-1:0] scan_total_ff, scan_total_in;

   // result beat
   logic                        rsp_valid_ff, rsp_valid_in;
   ndrm_pkg::outcome_type       outcome_ff, outcome_in;
   logic [ndrm_pkg::ADDR_W-1:0] index_ff, index_in;
   logic [ndrm_pkg::SIZE_W-1:0] msize_ff, msize_in;
   logic                        del_ff, del_in;

   ndrm_pkg::tbl_req_type tbl_req;
   ndrm_pkg::entry_type   wr_entry;
   ndrm_pkg::entry_type   rd_entry;
   logic                  match;
   logic                  accept;
   logic                  hidden;
   logic [ndrm_pkg::NAME_W-1:0] req_name;

   assign accept   = start && !busy;
   assign req_name = {req_name_bytes_24_31, req_name_bytes_16_23,
                      req_name_bytes_8_15, req_name_bytes_0_7};
   assign hidden   = (req_name_bytes_0_7[7:0] == ndrm_pkg::HIDDEN_MARK);

   ndrm_table u_table (
      .clock   (clock),
      .req     (tbl_req),
      .wr_data (wr_entry),
      .rd_data (rd_entry)
   );

   ndrm_cmp u_cmp (
      .rec_name       (rec_name_ff),
      .rec_size       (rec_size_ff),
      .entry          (rd_entry),
      .prefix_length  (prefix_length_ff),
      .size_tolerance (size_tolerance_ff),
      .match          (match)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_length_ff  <= ndrm_pkg::PLEN_W'(20);
         size_tolerance_ff <= '0;
         delete_enable_ff  <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            ndrm_pkg::CSR_PREFIX_LENGTH:  prefix_length_ff  <= csr_wdata[ndrm_pkg::PLEN_W-1:0];
            ndrm_pkg::CSR_SIZE_TOLERANCE: size_tolerance_ff <= csr_wdata;
            ndrm_pkg::CSR_DELETE_ENABLE:  delete_enable_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ndrm_pkg::ST_IDLE;
         issue_idx_ff   <= '0;
         chk_valid_ff   <= 1'b0;
         entry_count_ff <= '0;
         dup_total_ff   <= '0;
         scan_total_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         issue_idx_ff   <= issue_idx_in;
         chk_valid_ff   <= chk_valid_in;
         entry_count_ff <= entry_count_in;
         dup_total_ff   <= dup_total_in;
         scan_total_ff  <= scan_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      chk_idx_ff  <= chk_idx_in;
      rec_name_ff <= rec_name_in;
      rec_size_ff <= rec_size_in;
      outcome_ff  <= outcome_in;
      index_ff    <= index_in;
      msize_ff    <= msize_in;
      del_ff      <= del_in;
   end

   // sequencer: next state and datapath control
   always_comb begin
      logic hit;
      logic miss;
      hit  = chk_valid_ff && match;
      miss = !hit && (issue_idx_ff == entry_count_ff);

      state_in       = state_ff;
      issue_idx_in   = issue_idx_ff;
      chk_valid_in   = 1'b0;
      chk_idx_in     = chk_idx_ff;
      rec_name_in    = rec_name_ff;
      rec_size_in    = rec_size_ff;
      entry_count_in = entry_count_ff;
      dup_total_in   = dup_total_ff;
      scan_total_in  = scan_total_ff;
      rsp_valid_in   = 1'b0;
      outcome_in     = outcome_ff;
      index_in       = index_ff;
      msize_in       = msize_ff;
      del_in         = del_ff;

      tbl_req.wr_en   = 1'b0;
      tbl_req.wr_addr = entry_count_ff[ndrm_pkg::ADDR_W-1:0];
      tbl_req.rd_en   = 1'b0;
      tbl_req.rd_addr = issue_idx_ff[ndrm_pkg::ADDR_W-1:0];
      wr_entry.name   = rec_name_ff;
      wr_entry.size   = rec_size_ff;

      case (state_ff)
         ndrm_pkg::ST_IDLE: begin
            if (accept) begin
               if (scan_total_ff != ndrm_pkg::TOTAL_MAX) begin
                  scan_total_in = scan_total_ff + 1'b1;
               end
               rec_name_in  = req_name;
               rec_size_in  = req_file_size;
               issue_idx_in = '0;
               if (hidden) begin
                  rsp_valid_in = 1'b1;
                  outcome_in   = ndrm_pkg::OUT_HIDDEN;
                  index_in     = '0;
                  msize_in     = '0;
                  del_in       = 1'b0;
               end else begin
                  state_in = ndrm_pkg::ST_SCAN;
               end
            end
         end
         ndrm_pkg::ST_SCAN: begin
            // issue the next read while the previous entry is compared
            if (issue_idx_ff != entry_count_ff) begin
               tbl_req.rd_en = 1'b1;
               issue_idx_in  = issue_idx_ff + 1'b1;
               chk_valid_in  = 1'b1;
               chk_idx_in    = issue_idx_ff[ndrm_pkg::ADDR_W-1:0];
            end
            if (hit) begin
               state_in     = ndrm_pkg::ST_IDLE;
               chk_valid_in = 1'b0;
               rsp_valid_in = 1'b1;
               outcome_in   = ndrm_pkg::OUT_DUP;
               index_in     = chk_idx_ff;
               msize_in     = rd_entry.size;
               del_in       = delete_enable_ff;
               if (dup_total_ff != ndrm_pkg::TOTAL_MAX) begin
                  dup_total_in = dup_total_ff + 1'b1;
               end
            end else if (miss) begin
               state_in     = ndrm_pkg::ST_IDLE;
               chk_valid_in = 1'b0;
               rsp_valid_in = 1'b1;
               index_in     = '0;
               msize_in     = '0;
               del_in       = 1'b0;
               if (entry_count_ff == DEPTH_CNT) begin
                  outcome_in = ndrm_pkg::OUT_FULL;
               end else begin
                  outcome_in     = ndrm_pkg::OUT_NEW;
                  tbl_req.wr_en  = 1'b1;
                  entry_count_in = entry_count_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ndrm_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy                = (state_ff != ndrm_pkg::ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_outcome         = outcome_ff;
   assign rsp_match_index     = index_ff;
   assign rsp_matched_size    = msize_ff;
   assign rsp_delete_request  = del_ff;
   assign rsp_duplicate_total = dup_total_ff;
   assign rsp_scanned_total   = scan_total_ff;
   assign rsp_entries_stored  = entry_count_ff;

endmodule

### dv/tb_near_duplicate_record_matcher.sv
`timescale 1ns / 1ps

module tb_near_duplicate_record_matcher;

   localparam int    HALF_PERIOD = 5;
   localparam int    RESET_CYCLES = 12;
   localparam longint CYCLE_LIMIT = 12_000_000;
   localparam logic [ndrm_pkg::SIZE_W-1:0] SIZE_TOP = '1;

   // What one record should produce
   typedef struct {
      ndrm_pkg::outcome_type                outcome;
      logic [ndrm_pkg::ADDR_W-1:0]          match_idx;
      logic [ndrm_pkg::SIZE_W-1:0]          msize;
      logic                                 del;
      logic [ndrm_pkg::TOTAL_W-1:0]         dups;
      logic [ndrm_pkg::TOTAL_W-1:0]         scans;
      logic [ndrm_pkg::CNT_W-1:0]           stored;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [63:0] req_name_bytes_0_7 = '0;
   logic [63:0] req_name_bytes_8_15 = '0;
   logic [63:0] req_name_bytes_16_23 = '0;
   logic [63:0] req_name_bytes_24_31 = '0;
   logic [ndrm_pkg::SIZE_W-1:0] req_file_size = '0;
   logic rsp_valid;
   logic [1:0] rsp_outcome;
   logic [ndrm_pkg::ADDR_W-1:0] rsp_match_index;
   logic [ndrm_pkg::SIZE_W-1:0] rsp_matched_size;
   logic rsp_delete_request;
   logic [ndrm_pkg::TOTAL_W-1:0] rsp_duplicate_total;
   logic [ndrm_pkg::TOTAL_W-1:0] rsp_scanned_total;
   logic [ndrm_pkg::CNT_W-1:0] rsp_entries_stored;
   logic csr_write = 1'b0;
   logic [ndrm_pkg::CSR_IDX_W-1:0] csr_index = ndrm_pkg::CSR_PREFIX_LENGTH;
   logic [ndrm_pkg::SIZE_W-1:0] csr_wdata = '0;

   // Mirror of the table, counters and registers
   logic [ndrm_pkg::NAME_W-1:0] stored_names [ndrm_pkg::TABLE_DEPTH];
   logic [ndrm_pkg::SIZE_W-1:0] stored_sizes [ndrm_pkg::TABLE_DEPTH];
   int stored_count = 0;
   logic [ndrm_pkg::TOTAL_W-1:0] dup_seen = '0;
   logic [ndrm_pkg::TOTAL_W-1:0] scan_seen = '0;
   logic [ndrm_pkg::PLEN_W-1:0] cfg_prefix = ndrm_pkg::PLEN_W'(20);
   logic [ndrm_pkg::SIZE_W-1:0] cfg_tol = '0;
   logic cfg_delete = 1'b0;

   ndrm_pkg::entry_type pending_records [$];
   ndrm_pkg::entry_type recent_records [$];
   verdict_type expected_verdicts [$];
   ndrm_pkg::entry_type cur_record;
   bit beat_taken = 1'b0;
   int gap_style = 0;
   int fault_count = 0;
   longint cycle_count = 0;

   near_duplicate_record_matcher uut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_name_bytes_0_7   (req_name_bytes_0_7),
      .req_name_bytes_8_15  (req_name_bytes_8_15),
      .req_name_bytes_16_23 (req_name_bytes_16_23),
      .req_name_bytes_24_31 (req_name_bytes_24_31),
      .req_file_size        (req_file_size),
      .rsp_valid            (rsp_valid),
      .rsp_outcome          (rsp_outcome),
      .rsp_match_index      (rsp_match_index),
      .rsp_matched_size     (rsp_matched_size),
      .rsp_delete_request   (rsp_delete_request),
      .rsp_duplicate_total  (rsp_duplicate_total),
      .rsp_scanned_total    (rsp_scanned_total),
      .rsp_entries_stored   (rsp_entries_stored),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Prefix compare; stops early where both names end
   function automatic bit names_agree(logic [ndrm_pkg::NAME_W-1:0] a,
                                      logic [ndrm_pkg::NAME_W-1:0] b);
      int n;
      n = (cfg_prefix == 0 || cfg_prefix > ndrm_pkg::NAME_BYTES) ?
          ndrm_pkg::NAME_BYTES : int'(cfg_prefix);
      for (int i = 0; i < n; i++) begin
         if (a[8*i +: 8] != b[8*i +: 8]) return 1'b0;
         if (a[8*i +: 8] == 8'h00) return 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic bit sizes_agree(logic [ndrm_pkg::SIZE_W-1:0] a,
                                      logic [ndrm_pkg::SIZE_W-1:0] b);
      logic [ndrm_pkg::SIZE_W-1:0] diff;
      diff = (a >= b) ? a - b : b - a;
      return diff <= cfg_tol;
   endfunction

   // Works out the result of one record and updates the mirrored table
   function automatic verdict_type judge_record(ndrm_pkg::entry_type rec);
      verdict_type v;
      int hit;
      v.outcome = ndrm_pkg::OUT_NEW;
      v.match_idx = '0;
      v.msize = '0;
      v.del = 1'b0;
      hit = -1;
      if (scan_seen != ndrm_pkg::TOTAL_MAX) scan_seen++;
      if (rec.name[7:0] == ndrm_pkg::HIDDEN_MARK) begin
         v.outcome = ndrm_pkg::OUT_HIDDEN;
      end else begin
         for (int i = 0; i < stored_count; i++) begin
            if (names_agree(rec.name, stored_names[i]) &&
                sizes_agree(rec.size, stored_sizes[i])) begin
               hit = i;
               break;
            end
         end
         if (hit >= 0) begin
            v.outcome = ndrm_pkg::OUT_DUP;
            v.match_idx = ndrm_pkg::ADDR_W'(hit);
            v.msize = stored_sizes[hit];
            v.del = cfg_delete;
            if (dup_seen != ndrm_pkg::TOTAL_MAX) dup_seen++;
         end else if (stored_count >= ndrm_pkg::TABLE_DEPTH) begin
            v.outcome = ndrm_pkg::OUT_FULL;
         end else begin
            stored_names[stored_count] = rec.name;
            stored_sizes[stored_count] = rec.size;
            stored_count++;
         end
      end
      v.dups = dup_seen;
      v.scans = scan_seen;
      v.stored = ndrm_pkg::CNT_W'(stored_count);
      return v;
   endfunction

   function automatic logic [ndrm_pkg::NAME_W-1:0] pack_name(string s);
      logic [ndrm_pkg::NAME_W-1:0] n;
      n = '0;
      for (int i = 0; i < s.len() && i < ndrm_pkg::NAME_BYTES; i++) n[8*i +: 8] = s[i];
      return n;
   endfunction

   function automatic logic [ndrm_pkg::SIZE_W-1:0] random_size();
      case ($urandom_range(0, 3))
         0: return ndrm_pkg::SIZE_W'($urandom_range(0, 4096));
         1: return SIZE_TOP - ndrm_pkg::SIZE_W'($urandom_range(0, 4096));
         default: return ndrm_pkg::SIZE_W'({$urandom, $urandom});
      endcase
   endfunction

   // Moves a size around the tolerance boundary, clamped to the field range
   function automatic logic [ndrm_pkg::SIZE_W-1:0] nudge_size(logic [ndrm_pkg::SIZE_W-1:0] s);
      logic [ndrm_pkg::SIZE_W:0] wide;
      logic [ndrm_pkg::SIZE_W-1:0] delta;
      case ($urandom_range(0, 3))
         0: delta = cfg_tol;
         1: delta = cfg_tol + 1'b1;
         default: delta = ndrm_pkg::SIZE_W'($urandom_range(0, 1100));
      endcase
      if ($urandom_range(0, 1)) begin
         wide = {1'b0, s} + {1'b0, delta};
         return wide[ndrm_pkg::SIZE_W] ? SIZE_TOP : wide[ndrm_pkg::SIZE_W-1:0];
      end
      return (s >= delta) ? s - delta : '0;
   endfunction

   // Unique names for filling the table: no zero byte before the count
   function automatic logic [ndrm_pkg::NAME_W-1:0] fill_name(int k);
      logic [ndrm_pkg::NAME_W-1:0] n;
      n = '0;
      n[7:0] = 8'h46;
      n[15:8] = {1'b1, k[6:0]};
      n[23:16] = {1'b1, k[13:7]};
      return n;
   endfunction

   // Near-repeats of recent records about 45% of the time, so that hits are common
   function automatic ndrm_pkg::entry_type random_record();
      ndrm_pkg::entry_type rec;
      int pick;
      int pos;
      int len;
      pick = $urandom_range(0, 99);
      rec.name = '0;
      rec.size = random_size();
      if (pick < 45 && recent_records.size() != 0) begin
         rec = recent_records[$urandom_range(0, recent_records.size() - 1)];
         pos = $urandom_range(0, ndrm_pkg::NAME_BYTES - 1);
         case ($urandom_range(0, 3))
            0: ;
            1: rec.size = nudge_size(rec.size);
            2: begin
               for (int i = pos; i < ndrm_pkg::NAME_BYTES; i++)
                  rec.name[8*i +: 8] = 8'($urandom_range(0, 255));
            end
            default: begin
               for (int i = pos; i < ndrm_pkg::NAME_BYTES; i++) rec.name[8*i +: 8] = 8'h00;
               rec.size = nudge_size(rec.size);
            end
         endcase
      end else if (pick < 55) begin
         len = $urandom_range(1, ndrm_pkg::NAME_BYTES);
         for (int i = 1; i < len; i++) rec.name[8*i +: 8] = 8'($urandom_range(0, 255));
         rec.name[7:0] = ndrm_pkg::HIDDEN_MARK;
      end else if (pick < 62) begin
         if ($urandom_range(0, 1)) begin
            for (int i = 0; i < ndrm_pkg::NAME_W / 32; i++) rec.name[32*i +: 32] = $urandom;
         end
      end else begin
         len = $urandom_range(0, ndrm_pkg::NAME_BYTES);
         for (int i = 0; i < len; i++) rec.name[8*i +: 8] = 8'($urandom_range(0, 255));
      end
      if (rec.name[7:0] != ndrm_pkg::HIDDEN_MARK) begin
         recent_records.push_back(rec);
         if (recent_records.size() > 48) void'(recent_records.pop_front());
      end
      return rec;
   endfunction

   task automatic push_record(logic [ndrm_pkg::NAME_W-1:0] n, logic [ndrm_pkg::SIZE_W-1:0] s);
      ndrm_pkg::entry_type rec;
      rec.name = n;
      rec.size = s;
      pending_records.push_back(rec);
   endtask

   // Blocks until every queued record is through and the block is quiet
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_records.size() != 0 || start || expected_verdicts.size() != 0 || busy);
   endtask

   task automatic write_reg(logic [ndrm_pkg::CSR_IDX_W-1:0] idx,
                            logic [ndrm_pkg::SIZE_W-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         ndrm_pkg::CSR_PREFIX_LENGTH: cfg_prefix = val[ndrm_pkg::PLEN_W-1:0];
         ndrm_pkg::CSR_SIZE_TOLERANCE: cfg_tol = val;
         ndrm_pkg::CSR_DELETE_ENABLE: cfg_delete = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_config(logic [ndrm_pkg::PLEN_W-1:0] plen,
                             logic [ndrm_pkg::SIZE_W-1:0] tol, logic del);
      wait_idle();
      write_reg(ndrm_pkg::CSR_PREFIX_LENGTH, ndrm_pkg::SIZE_W'(plen));
      write_reg(ndrm_pkg::CSR_SIZE_TOLERANCE, tol);
      write_reg(ndrm_pkg::CSR_DELETE_ENABLE, ndrm_pkg::SIZE_W'(del));
   endtask

   task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         fault_count++;
      end
   endtask

   // Beat acceptance and prediction
   always @(posedge clock) begin : record_accept
      beat_taken = !reset && start && !busy;
      if (beat_taken) expected_verdicts.push_back(judge_record(cur_record));
   end

   // Sender: bursts of records with gaps between them
   always @(negedge clock) begin : record_driver
      logic next_start;
      int burst_left;
      int gap_left;
      next_start = 1'b0;
      if (reset) begin
         burst_left = 1;
         gap_left = 0;
      end else if (start && !beat_taken) begin
         next_start = 1'b1;
      end else begin
         if (start) begin
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 16);
               case (gap_style)
                  0: gap_left = 0;
                  1: gap_left = $urandom_range(0, 6);
                  default: gap_left = ($urandom_range(0, 5) == 0) ?
                                      $urandom_range(7, ndrm_pkg::TABLE_DEPTH + 80) :
                                      $urandom_range(0, 6);
               endcase
            end
         end
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_records.size() != 0) begin
            cur_record = pending_records.pop_front();
            req_name_bytes_0_7 <= cur_record.name[63:0];
            req_name_bytes_8_15 <= cur_record.name[127:64];
            req_name_bytes_16_23 <= cur_record.name[191:128];
            req_name_bytes_24_31 <= cur_record.name[255:192];
            req_file_size <= cur_record.size;
            next_start = 1'b1;
         end
      end
      start <= next_start;
   end

   // Result checking against the oldest prediction
   always @(posedge clock) begin : result_monitor
      verdict_type want;
      if (!reset && rsp_valid) begin
         if (expected_verdicts.size() == 0) begin
            $error("result beat with no record outstanding");
            fault_count++;
         end else begin
            want = expected_verdicts.pop_front();
            check_field("outcome", 64'(want.outcome), 64'(rsp_outcome));
            check_field("match_index", 64'(want.match_idx), 64'(rsp_match_index));
            check_field("matched_size", 64'(want.msize), 64'(rsp_matched_size));
            check_field("delete_request", 64'(want.del), 64'(rsp_delete_request));
            check_field("duplicate_total", 64'(want.dups), 64'(rsp_duplicate_total));
            check_field("scanned_total", 64'(want.scans), 64'(rsp_scanned_total));
            check_field("entries_stored", 64'(want.stored), 64'(rsp_entries_stored));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      logic [ndrm_pkg::NAME_W-1:0] n;
      ndrm_pkg::entry_type last_fill;
      int fill_seq;
      fill_seq = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: defaults after reset (prefix 20, exact size, no delete)
      gap_style = 1;
      push_record(pack_name("report_final.pdf"), 63'd1000);
      push_record(pack_name("report_final.pdf"), 63'd1000);
      push_record(pack_name("report_final.pdf"), 63'd1001);
      push_record(pack_name(".hidden"), 63'd42);
      push_record('0, '0);
      push_record('0, '0);
      push_record('1, SIZE_TOP);
      n = '1;
      n[ndrm_pkg::NAME_W-1 -: 8] = 8'h00;
      push_record(n, SIZE_TOP);
      push_record(pack_name("."), '0);
      push_record(pack_name("abc"), 63'd5);
      n = pack_name("abc");
      n[ndrm_pkg::NAME_W-1:32] = '1;
      push_record(n, 63'd5);

      // Long prefix, widest tolerance, deletion on
      set_config(6'd63, SIZE_TOP, 1'b1);
      n = '1;
      n[ndrm_pkg::NAME_W-1 -: 8] = 8'h01;
      push_record(n, '0);
      push_record(pack_name("report_final.pdf"), 63'd7);
      push_record({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom}, SIZE_TOP);

      // One-byte prefix: earliest entry inside the tolerance wins
      set_config(6'd1, 63'd5, 1'b0);
      push_record(pack_name("rx"), 63'd1004);
      push_record(pack_name("r"), 63'd1006);
      push_record(pack_name("zzz"), '0);

      // Zero prefix compares the whole name
      set_config(6'd0, 63'd5, 1'b1);
      push_record(pack_name("report_final.pdf"), 63'd1000);
      push_record(pack_name("report_final"), 63'd1000);
      push_record('1, SIZE_TOP - 63'd5);

      // Random phases, each under its own register setting
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_config(6'd0, '0, 1'b0);
            1: set_config(6'd32, SIZE_TOP, 1'b1);
            2: set_config(6'd63, 63'd1, 1'b0);
            3: set_config(6'd1, 63'd1000, 1'b1);
            4: set_config(6'd20, random_size(), 1'b0);
            default: set_config(ndrm_pkg::PLEN_W'($urandom_range(0, 63)),
                                $urandom_range(0, 1) ?
                                   ndrm_pkg::SIZE_W'($urandom_range(0, 255)) :
                                   random_size(),
                                1'($urandom_range(0, 1)));
         endcase
         gap_style = ph % 3;
         repeat (62) pending_records.push_back(random_record());
      end

      // Fill the table to the brim with distinct names
      set_config(6'd0, '0, 1'b1);
      gap_style = 1;
      last_fill.name = '0;
      last_fill.size = '0;
      while (stored_count < ndrm_pkg::TABLE_DEPTH) begin
         for (int k = stored_count; k < ndrm_pkg::TABLE_DEPTH; k++) begin
            last_fill.name = fill_name(fill_seq);
            last_fill.size = random_size();
            pending_records.push_back(last_fill);
            fill_seq++;
         end
         wait_idle();
      end

      // Full table: a miss is refused, hits and hidden names behave as usual
      gap_style = 2;
      push_record(fill_name(fill_seq), random_size());
      pending_records.push_back(last_fill);
      push_record(pack_name("report_final.pdf"), 63'd1000);
      push_record(pack_name(".profile"), random_size());
      repeat (8) pending_records.push_back(random_record());
      set_config(6'd33, SIZE_TOP, 1'b0);
      repeat (6) pending_records.push_back(random_record());

      // Drain, then leave room for any stray beat
      wait_idle();
      repeat (ndrm_pkg::TABLE_DEPTH + 4) @(posedge clock);
      if (fault_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
